>>> src/jtl_pkg.sv
// Package for the JSON token lexer: token, mode and number-automaton types,
// character classes and the keyword and number transition functions.
// No dependencies.
package jtl_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_TERM   = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    NS_START = 4'd0,
    NS_MINUS = 4'd1,
    NS_INT   = 4'd2,
    NS_DOT   = 4'd3,
    NS_FRAC  = 4'd4,
    NS_EXP   = 4'd5,
    NS_ESIGN = 4'd6,
    NS_EDIG  = 4'd7,
    NS_BAD   = 4'd8
  } num_e;

  typedef enum logic [3:0] {
    TOK_INVALID  = 4'd0,
    TOK_NULL     = 4'd1,
    TOK_FALSE    = 4'd2,
    TOK_TRUE     = 4'd3,
    TOK_LBRACE   = 4'd4,
    TOK_RBRACE   = 4'd5,
    TOK_LBRACKET = 4'd6,
    TOK_RBRACKET = 4'd7,
    TOK_COMMA    = 4'd8,
    TOK_COLON    = 4'd9,
    TOK_STRING   = 4'd10,
    TOK_NUMBER   = 4'd11
  } tok_e;

  typedef enum logic [2:0] {
    CLS_SPACE = 3'd0,
    CLS_PUNCT = 3'd1,
    CLS_QUOTE = 3'd2,
    CLS_TERM  = 3'd3,
    CLS_OTHER = 3'd4
  } cls_e;

  typedef struct packed {
    logic [2:0] idx;
    logic [2:0] mask;
  } kw_t;

  localparam kw_t KW_RESET = '{idx: 3'd0, mask: 3'b111};
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [2:0] KW_IDX_MAX = 3'd7;

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LOW_E    = 8'h65;
  localparam logic [7:0] CH_UP_E     = 8'h45;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return is_digit(c) || (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) ||
           c == CH_MINUS || c == CH_PLUS || c == CH_DOT;
  endfunction

  function automatic tok_e punct_type(input logic [7:0] c);
    tok_e t;
    case (c)
      CH_LBRACE:   t = TOK_LBRACE;
      CH_RBRACE:   t = TOK_RBRACE;
      CH_LBRACKET: t = TOK_LBRACKET;
      CH_RBRACKET: t = TOK_RBRACKET;
      CH_COMMA:    t = TOK_COMMA;
      CH_COLON:    t = TOK_COLON;
      default:     t = TOK_INVALID;
    endcase
    return t;
  endfunction

  function automatic cls_e classify(input logic [7:0] c);
    cls_e k;
    if (c inside {8'h20, [8'h09:8'h0D]}) begin
      k = CLS_SPACE;
    end else if (punct_type(c) != TOK_INVALID) begin
      k = CLS_PUNCT;
    end else if (c == CH_QUOTE) begin
      k = CLS_QUOTE;
    end else if (is_term(c)) begin
      k = CLS_TERM;
    end else begin
      k = CLS_OTHER;
    end
    return k;
  endfunction

  function automatic num_e number_next(input num_e s, input logic [7:0] c);
    logic d;
    logic e;
    num_e n;
    d = is_digit(c);
    e = (c == CH_LOW_E) || (c == CH_UP_E);
    case (s)
      NS_START: n = (c == CH_MINUS) ? NS_MINUS : (d ? NS_INT : NS_BAD);
      NS_MINUS: n = d ? NS_INT : NS_BAD;
      NS_INT:   n = d ? NS_INT : ((c == CH_DOT) ? NS_DOT : (e ? NS_EXP : NS_BAD));
      NS_DOT:   n = d ? NS_FRAC : NS_BAD;
      NS_FRAC:  n = d ? NS_FRAC : (e ? NS_EXP : NS_BAD);
      NS_EXP:   n = (c == CH_PLUS || c == CH_MINUS) ? NS_ESIGN : (d ? NS_EDIG : NS_BAD);
      NS_ESIGN: n = d ? NS_EDIG : NS_BAD;
      NS_EDIG:  n = d ? NS_EDIG : NS_BAD;
      default:  n = NS_BAD;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0:    n = 3'd4;
      2'd1:    n = 3'd5;
      2'd2:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_letter(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      2'd0: begin
        case (idx)
          3'd0:    ch = 8'h6E;
          3'd1:    ch = 8'h75;
          3'd2:    ch = 8'h6C;
          3'd3:    ch = 8'h6C;
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0:    ch = 8'h66;
          3'd1:    ch = 8'h61;
          3'd2:    ch = 8'h6C;
          3'd3:    ch = 8'h73;
          3'd4:    ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0:    ch = 8'h74;
          3'd1:    ch = 8'h72;
          3'd2:    ch = 8'h75;
          3'd3:    ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic kw_t keyword_next(input kw_t m, input logic [7:0] c);
    logic [7:0] lc;
    kw_t r;
    lc = (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
    r = m;
    for (int k = 0; k < 3; k++) begin
      if (m.idx >= kw_len(2'(k)) || kw_letter(2'(k), m.idx) != lc) begin
        r.mask[k] = 1'b0;
      end
    end
    if (m.idx != KW_IDX_MAX) begin
      r.idx = m.idx + 3'd1;
    end
    return r;
  endfunction

  function automatic tok_e term_type(input num_e s, input kw_t m);
    tok_e t;
    if (m.mask[0] && m.idx == kw_len(2'd0)) begin
      t = TOK_NULL;
    end else if (m.mask[1] && m.idx == kw_len(2'd1)) begin
      t = TOK_FALSE;
    end else if (m.mask[2] && m.idx == kw_len(2'd2)) begin
      t = TOK_TRUE;
    end else if (s == NS_INT || s == NS_FRAC || s == NS_EDIG) begin
      t = TOK_NUMBER;
    end else begin
      t = TOK_INVALID;
    end
    return t;
  endfunction

endpackage

>>> src/jtl_front.sv
// Lexer front end: classifies each transferred character, keeps the lexer
// state and forms up to two tokens per item for the queue.
// Depends on jtl_pkg.
module jtl_front #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     command_i,
  input  logic [7:0]               character_i,
  output logic                     push_o,
  output logic                     two_o,
  output logic [3:0]               type0_o,
  output logic [POSITION_BITS-1:0] start0_o,
  output logic [LENGTH_BITS-1:0]   len0_o,
  output logic [3:0]               type1_o,
  output logic [POSITION_BITS-1:0] start1_o
);

  jtl_pkg::mode_e mode_q, mode_d;
  jtl_pkg::num_e  num_q, num_d;
  jtl_pkg::kw_t   kw_q, kw_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] cstart_q, cstart_d;
  logic [LENGTH_BITS-1:0]   clen_q, clen_d;

  jtl_pkg::cls_e cls;
  jtl_pkg::tok_e idle_tok;
  jtl_pkg::tok_e term_tok;
  logic idle_emit;
  logic [LENGTH_BITS-1:0] clen_inc;

  assign cls       = jtl_pkg::classify(character_i);
  assign idle_tok  = (cls == jtl_pkg::CLS_PUNCT) ? jtl_pkg::punct_type(character_i)
                                                 : jtl_pkg::TOK_INVALID;
  assign idle_emit = (cls == jtl_pkg::CLS_PUNCT) || (cls == jtl_pkg::CLS_OTHER);
  assign term_tok  = jtl_pkg::term_type(num_q, kw_q);
  assign clen_inc  = (clen_q == '1) ? clen_q : clen_q + LENGTH_BITS'(1);

  always_comb begin : next_state
    mode_d   = mode_q;
    num_d    = num_q;
    kw_d     = kw_q;
    pos_d    = pos_q;
    cstart_d = cstart_q;
    clen_d   = clen_q;
    if (accept_i) begin
      if (command_i) begin
        mode_d   = jtl_pkg::MODE_IDLE;
        num_d    = jtl_pkg::NS_START;
        kw_d     = jtl_pkg::KW_RESET;
        pos_d    = '0;
        cstart_d = '0;
        clen_d   = '0;
      end else begin
        pos_d = pos_q + POSITION_BITS'(1);
        if (mode_q == jtl_pkg::MODE_STRING) begin
          if (cls == jtl_pkg::CLS_QUOTE) begin
            mode_d = jtl_pkg::MODE_IDLE;
          end else begin
            clen_d = clen_inc;
          end
        end else if (mode_q == jtl_pkg::MODE_TERM && cls == jtl_pkg::CLS_TERM) begin
          num_d  = jtl_pkg::number_next(num_q, character_i);
          kw_d   = jtl_pkg::keyword_next(kw_q, character_i);
          clen_d = clen_inc;
        end else begin
          case (cls)
            jtl_pkg::CLS_QUOTE: begin
              mode_d   = jtl_pkg::MODE_STRING;
              cstart_d = pos_q + POSITION_BITS'(1);
              clen_d   = '0;
            end
            jtl_pkg::CLS_TERM: begin
              mode_d   = jtl_pkg::MODE_TERM;
              cstart_d = pos_q;
              clen_d   = LENGTH_BITS'(1);
              num_d    = jtl_pkg::number_next(jtl_pkg::NS_START, character_i);
              kw_d     = jtl_pkg::keyword_next(jtl_pkg::KW_RESET, character_i);
            end
            default: mode_d = jtl_pkg::MODE_IDLE;
          endcase
        end
      end
    end
  end

  always_comb begin : outputs
    push_o   = 1'b0;
    two_o    = 1'b0;
    type0_o  = idle_tok;
    start0_o = pos_q;
    len0_o   = LENGTH_BITS'(1);
    type1_o  = idle_tok;
    start1_o = pos_q;
    if (accept_i) begin
      if (command_i) begin
        push_o = 1'b1;
        case (mode_q)
          jtl_pkg::MODE_STRING: begin
            type0_o  = jtl_pkg::TOK_INVALID;
            start0_o = cstart_q;
            len0_o   = clen_q;
          end
          jtl_pkg::MODE_TERM: begin
            type0_o  = term_tok;
            start0_o = cstart_q;
            len0_o   = clen_q;
          end
          default: begin
            type0_o = jtl_pkg::TOK_INVALID;
            len0_o  = '0;
          end
        endcase
      end else begin
        case (mode_q)
          jtl_pkg::MODE_STRING: begin
            push_o   = (cls == jtl_pkg::CLS_QUOTE);
            type0_o  = jtl_pkg::TOK_STRING;
            start0_o = cstart_q;
            len0_o   = clen_q;
          end
          jtl_pkg::MODE_TERM: begin
            push_o   = (cls != jtl_pkg::CLS_TERM);
            two_o    = idle_emit;
            type0_o  = term_tok;
            start0_o = cstart_q;
            len0_o   = clen_q;
          end
          default: push_o = idle_emit;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= jtl_pkg::MODE_IDLE;
      num_q    <= jtl_pkg::NS_START;
      kw_q     <= jtl_pkg::KW_RESET;
      pos_q    <= '0;
      cstart_q <= '0;
      clen_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      num_q    <= num_d;
      kw_q     <= kw_d;
      pos_q    <= pos_d;
      cstart_q <= cstart_d;
      clen_q   <= clen_d;
    end
  end

endmodule

>>> src/jtl_queue.sv
// Short register queue between the lexer front end and the output stage.
// Holds one packed token pair per entry. Depends on jtl_pkg.
module jtl_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = (jtl_pkg::QUEUE_DEPTH > 1) ? $clog2(jtl_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(jtl_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(jtl_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(jtl_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_q [jtl_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] count_q, count_d;

  assign ready_o = (count_q != FULL_CNT);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == LAST_SLOT) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST_SLOT) ? '0 : rd_q + PW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> ready_o)
    else $error("queue push while full");
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("queue count out of range");
`endif

endmodule

>>> src/jtl_back.sv
// Output stage: takes token pairs from the queue and drives them one per
// transfer from an output register. Depends on jtl_pkg.
module jtl_back #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     head_valid_i,
  input  logic                     two_i,
  input  logic [3:0]               type0_i,
  input  logic [POSITION_BITS-1:0] start0_i,
  input  logic [LENGTH_BITS-1:0]   len0_i,
  input  logic [3:0]               type1_i,
  input  logic [POSITION_BITS-1:0] start1_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [3:0]               token_type_o,
  output logic [POSITION_BITS-1:0] token_start_o,
  output logic [LENGTH_BITS-1:0]   token_length_o,
  output logic                     last_result_o
);

  logic valid_q, valid_d;
  logic second_q, second_d;
  logic load;
  logic [3:0]               type_q, type_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0]   len_q, len_d;
  logic                     last_q, last_d;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    type_d   = type_q;
    start_d  = start_q;
    len_d    = len_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (second_q) begin
          type_d   = type1_i;
          start_d  = start1_i;
          len_d    = LENGTH_BITS'(1);
          last_d   = 1'b1;
          second_d = 1'b0;
          pop_o    = 1'b1;
        end else begin
          type_d   = type0_i;
          start_d  = start0_i;
          len_d    = len0_i;
          last_d   = !two_i;
          second_d = two_i;
          pop_o    = !two_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q  <= type_d;
    start_q <= start_d;
    len_q   <= len_d;
    last_q  <= last_d;
  end

  assign out_valid_o    = valid_q;
  assign token_type_o   = type_q;
  assign token_start_o  = start_q;
  assign token_length_o = len_q;
  assign last_result_o  = last_q;

endmodule

>>> src/json_token_lexer_core.sv
// JSON token lexer, top level: front end, token queue and output stage.
// Depends on jtl_pkg, jtl_front, jtl_queue and jtl_back.
//
// Input channel: one transfer carries a character (command_i = 0) or an
// end-of-input mark (command_i = 1) with character_i ignored. Output channel:
// one transfer carries one token: type, start offset, length and last_result_o,
// which marks the final token caused by that input transfer.
// An input transfer yields zero, one or two tokens; end of input always yields
// exactly one and returns the lexer, including the byte offset, to its reset
// state.
// Throughput: one input transfer per cycle while in_stall_o is low; an item
// that yields two tokens sends both in turn via the output register, which
// drives one token per cycle while out_stall_i is low. A token passes a queue
// write and then an output register load before out_valid_o shows it.
// Reset clears the lexer state, empties the queue and invalidates the output
// register. When the receiver stalls, the output register holds, the two-entry
// queue fills and in_stall_o rises once the queue is full.
module json_token_lexer_core #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     command_i,
  input  logic [7:0]               character_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [3:0]               token_type_o,
  output logic [POSITION_BITS-1:0] token_start_o,
  output logic [LENGTH_BITS-1:0]   token_length_o,
  output logic                     last_result_o
);

  localparam int unsigned ENTRY_W = 1 + 4 + POSITION_BITS + LENGTH_BITS + 4 + POSITION_BITS;

  logic accept;
  logic push;
  logic ready;
  logic pop;
  logic head_valid;
  logic [ENTRY_W-1:0] push_data;
  logic [ENTRY_W-1:0] head_data;

  logic                     f_two, h_two;
  logic [3:0]               f_type0, h_type0;
  logic [POSITION_BITS-1:0] f_start0, h_start0;
  logic [LENGTH_BITS-1:0]   f_len0, h_len0;
  logic [3:0]               f_type1, h_type1;
  logic [POSITION_BITS-1:0] f_start1, h_start1;

  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  jtl_front #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (command_i),
    .character_i(character_i),
    .push_o     (push),
    .two_o      (f_two),
    .type0_o    (f_type0),
    .start0_o   (f_start0),
    .len0_o     (f_len0),
    .type1_o    (f_type1),
    .start1_o   (f_start1)
  );

  assign push_data = {f_two, f_type0, f_start0, f_len0, f_type1, f_start1};

  jtl_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .ready_o(ready),
    .pop_i  (pop),
    .valid_o(head_valid),
    .data_o (head_data)
  );

  assign {h_two, h_type0, h_start0, h_len0, h_type1, h_start1} = head_data;

  jtl_back #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .two_i         (h_two),
    .type0_i       (h_type0),
    .start0_i      (h_start0),
    .len0_i        (h_len0),
    .type1_i       (h_type1),
    .start1_i      (h_start1),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_type_o  (token_type_o),
    .token_start_o (token_start_o),
    .token_length_o(token_length_o),
    .last_result_o (last_result_o)
  );

endmodule
